[hdl/nearest_point_outside_box_defines.svh]
// Assertion macros shared by the checker of nearest_point_outside_box.
// No dependencies.
`ifndef NEAREST_POINT_OUTSIDE_BOX_DEFINES_SVH
`define NEAREST_POINT_OUTSIDE_BOX_DEFINES_SVH

// same-cycle implication, disabled in reset
`define NPOB_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("npob assertion failed");

// next-cycle implication, disabled in reset
`define NPOB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("npob assertion failed");

// next-cycle implication that also holds across reset
`define NPOB_ASSERT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("npob assertion failed");

`endif

[hdl/npob_pkg.sv]
// Types and constants of nearest_point_outside_box.
// No dependencies.
package npob_pkg;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic REG_NODE_COUNT = 1'b0;

   localparam int COORD_W = 32;
   localparam int GROUP_W = 16;
   localparam int COUNT_W = 11;
   localparam int SQ_W    = 66;
   localparam int ROOT_W  = 33;

   typedef struct packed {
      logic                      kind;
      logic [9:0]                node_index;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic [GROUP_W-1:0]        node_group;
      logic signed [COORD_W-1:0] box_lo_x;
      logic signed [COORD_W-1:0] box_lo_y;
      logic signed [COORD_W-1:0] box_lo_z;
      logic signed [COORD_W-1:0] box_hi_x;
      logic signed [COORD_W-1:0] box_hi_y;
      logic signed [COORD_W-1:0] box_hi_z;
   } item_type;

   typedef struct packed {
      logic                      found;
      logic signed [COORD_W-1:0] near_x;
      logic signed [COORD_W-1:0] near_y;
      logic signed [COORD_W-1:0] near_z;
      logic [GROUP_W-1:0]        near_group;
      logic [ROOT_W-1:0]         near_distance;
   } result_type;

endpackage

[hdl/nearest_point_outside_box.sv]
// Top level of nearest_point_outside_box: queue ports, register port, front and back.
// Depends on npob_pkg, npob_front, npob_back.
//
// Nearest point outside a box. Load transfers (kind 0) write one point entry
// in the back unit and give no result. A query transfer (kind 1) scans
// entries 0 .. node_count-1 (capped at MAX_POINTS) through a four-stage
// pipeline fed by one store read port at one entry per cycle, then runs a
// bit-serial square root and puts its result on the rsp_ ports; the root is
// skipped when no point qualifies, and the scan too when node_count is zero.
// A two-entry input queue accepts new transfers while the back unit works
// and a finished result waits on the rsp_ ports. node_count is at byte
// address 0 and should only be written while the block is idle.
module nearest_point_outside_box
   import npob_pkg::*;
#(
   parameter int MAX_POINTS = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   // input queue
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_kind,
   input  logic [9:0]                req_node_index,
   input  logic signed [COORD_W-1:0] req_pos_x,
   input  logic signed [COORD_W-1:0] req_pos_y,
   input  logic signed [COORD_W-1:0] req_pos_z,
   input  logic [GROUP_W-1:0]        req_node_group,
   input  logic signed [COORD_W-1:0] req_box_lo_x,
   input  logic signed [COORD_W-1:0] req_box_lo_y,
   input  logic signed [COORD_W-1:0] req_box_lo_z,
   input  logic signed [COORD_W-1:0] req_box_hi_x,
   input  logic signed [COORD_W-1:0] req_box_hi_y,
   input  logic signed [COORD_W-1:0] req_box_hi_z,
   // result queue
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic                      rsp_found,
   output logic signed [COORD_W-1:0] rsp_near_x,
   output logic signed [COORD_W-1:0] rsp_near_y,
   output logic signed [COORD_W-1:0] rsp_near_z,
   output logic [GROUP_W-1:0]        rsp_near_group,
   output logic [ROOT_W-1:0]         rsp_near_distance,
   // register port
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [2:0]                csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);
   item_type           item_in, item_q;
   logic               link_valid, link_pop;
   result_type         result;
   logic               out_valid;
   logic [COUNT_W-1:0] node_count_ff, node_count_in;

   // register port: always ready, write lands in the access cycle
   assign csr_pready = 1'b1;
   always_comb begin
      node_count_in = node_count_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == REG_NODE_COUNT) begin
         node_count_in = csr_pwdata[COUNT_W-1:0];
      end
      csr_prdata = (csr_paddr[2] == REG_NODE_COUNT) ? 32'(node_count_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   assign item_in = '{kind: req_kind, node_index: req_node_index,
                      pos_x: req_pos_x, pos_y: req_pos_y, pos_z: req_pos_z,
                      node_group: req_node_group,
                      box_lo_x: req_box_lo_x, box_lo_y: req_box_lo_y,
                      box_lo_z: req_box_lo_z, box_hi_x: req_box_hi_x,
                      box_hi_y: req_box_hi_y, box_hi_z: req_box_hi_z};

   npob_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .full     (req_full),
      .item_in  (item_in),
      .item_out (item_q),
      .pop      (link_pop),
      .valid    (link_valid)
   );

   npob_back #(.MAX_POINTS(MAX_POINTS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (item_q),
      .link_valid (link_valid),
      .link_pop   (link_pop),
      .node_count (node_count_ff),
      .out_valid  (out_valid),
      .out_pop    (rsp_pop),
      .result     (result)
   );

   // result register shown while not empty
   assign rsp_empty         = !out_valid;
   assign rsp_found         = result.found;
   assign rsp_near_x        = result.near_x;
   assign rsp_near_y        = result.near_y;
   assign rsp_near_z        = result.near_z;
   assign rsp_near_group    = result.near_group;
   assign rsp_near_distance = result.near_distance;
endmodule

[hdl/npob_ram.sv]
// Generic single-port RAM, registered read.
// No dependencies.
module npob_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

[hdl/npob_front.sv]
// Front of nearest_point_outside_box: two-entry input queue.
// Depends on npob_pkg.
module npob_front
   import npob_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  item_type item_in,
   output item_type item_out,
   input  logic     pop,
   output logic     valid
);
   item_type   slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full     = (cnt_ff == 2'd2);
   assign do_push  = push && !full;
   assign do_pop   = pop && (cnt_ff != 2'd0);
   assign valid    = (cnt_ff != 2'd0);
   assign item_out = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff ^ do_push;
      rd_in  = rd_ff ^ do_pop;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         slot_ff[wr_ff] <= item_in;
      end
   end
endmodule

[hdl/npob_sqrt.sv]
// Bit-serial floor square root, two radicand bits per cycle.
// Depends on npob_pkg.
module npob_sqrt
   import npob_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              done,
   input  logic [SQ_W-1:0]   radicand,
   output logic [ROOT_W-1:0] root
);
   logic [SQ_W-1:0]   rad_ff, rad_in;
   logic [35:0]       rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [35:0]       shifted, trial;

   assign shifted = {rem_ff[33:0], rad_ff[SQ_W-1 -: 2]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign done    = done_ff;
   assign root    = root_ff;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start && !busy_ff) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 6'(ROOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[SQ_W-3:0], 2'b00};
         if (shifted >= trial) begin
            rem_in  = shifted - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end
endmodule

[hdl/npob_back.sv]
// Back of nearest_point_outside_box: point store, scan pipeline, result register.
// Depends on npob_pkg, npob_ram, npob_sqrt.
module npob_back
   import npob_pkg::*;
#(
   parameter int MAX_POINTS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  item_type           item,
   input  logic               link_valid,
   output logic               link_pop,
   input  logic [COUNT_W-1:0] node_count,
   output logic               out_valid,
   input  logic               out_pop,
   output result_type         result
);
   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = AW + 1;
   localparam int DW = 3 * COORD_W + GROUP_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_ROOT  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in, last_ff, last_in, n_sat;
   item_type      q_ff, q_in;

   // pipeline: v0 read issued, v1 diffs, v2 squares, v3 sum
   logic v0_ff, v0_in, v1_ff, v2_ff, v3_ff;
   logic [DW-1:0] pt1_ff, pt2_ff, pt3_ff;
   logic          in1_ff, in2_ff, in3_ff;
   logic [COORD_W-1:0] d1_ff [3];
   logic [63:0]        s2_ff [3];
   logic [SQ_W-1:0]    sum3_ff;

   logic            found_ff, found_in;
   logic [DW-1:0]   best_pt_ff, best_pt_in;
   logic [SQ_W-1:0] best_sq_ff, best_sq_in;

   logic       outv_ff, outv_in;
   result_type out_ff, out_in;

   logic               ram_we;
   logic [AW-1:0]      ram_addr;
   logic [DW-1:0]      ram_wdata, ram_rdata;
   logic signed [COORD_W-1:0] p [3], qp [3], lo [3], hi [3];
   logic [COORD_W-1:0] d_in [3];
   logic               inside_in;
   logic               root_start, root_done;
   logic [ROOT_W-1:0]  root;
   logic               load_ok;

   always_comb begin
      if (32'(node_count) > 32'(MAX_POINTS)) begin
         n_sat = CW'(MAX_POINTS);
      end else begin
         n_sat = CW'(node_count);
      end
   end

   assign load_ok = 32'(item.node_index) < 32'(MAX_POINTS);

   always_comb begin
      ram_we    = (state_ff == ST_IDLE) && link_valid && (item.kind == KIND_LOAD) && load_ok;
      ram_addr  = (state_ff == ST_SCAN) ? idx_ff[AW-1:0] : AW'(32'(item.node_index));
      ram_wdata = {item.pos_x, item.pos_y, item.pos_z, item.node_group};
   end

   npob_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // stage 1: axis distances and box test on the read point
   always_comb begin
      p[0]  = ram_rdata[DW-1 -: COORD_W];
      p[1]  = ram_rdata[DW-COORD_W-1 -: COORD_W];
      p[2]  = ram_rdata[GROUP_W +: COORD_W];
      qp[0] = q_ff.pos_x;    qp[1] = q_ff.pos_y;    qp[2] = q_ff.pos_z;
      lo[0] = q_ff.box_lo_x; lo[1] = q_ff.box_lo_y; lo[2] = q_ff.box_lo_z;
      hi[0] = q_ff.box_hi_x; hi[1] = q_ff.box_hi_y; hi[2] = q_ff.box_hi_z;
      inside_in = 1'b1;
      for (int a = 0; a < 3; a++) begin
         logic signed [COORD_W:0] diff;
         diff = {p[a][COORD_W-1], p[a]} - {qp[a][COORD_W-1], qp[a]};
         d_in[a] = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
         if (!(p[a] > lo[a] && p[a] < hi[a])) begin
            inside_in = 1'b0;
         end
      end
   end

   // best-so-far update on the summed square; strict less keeps the earlier entry
   always_comb begin
      found_in   = found_ff;
      best_pt_in = best_pt_ff;
      best_sq_in = best_sq_ff;
      if (v3_ff && !in3_ff && (!found_ff || sum3_ff < best_sq_ff)) begin
         found_in   = 1'b1;
         best_pt_in = pt3_ff;
         best_sq_in = sum3_ff;
      end
   end

   assign root_start = (state_ff == ST_DRAIN) && !v0_ff && !v1_ff && !v2_ff && !v3_ff
                       && found_ff;

   npob_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .done     (root_done),
      .radicand (best_sq_ff),
      .root     (root)
   );

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      last_in   = last_ff;
      q_in      = q_ff;
      v0_in     = 1'b0;
      link_pop  = 1'b0;
      outv_in   = outv_ff && !out_pop;
      out_in    = out_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (link_valid) begin
               link_pop = 1'b1;
               if (item.kind == KIND_QUERY) begin
                  q_in    = item;
                  idx_in  = '0;
                  last_in = n_sat - CW'(1);
                  state_in = (n_sat == '0) ? ST_DONE : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            v0_in  = 1'b1;
            idx_in = idx_ff + CW'(1);
            if (idx_ff == last_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!v0_ff && !v1_ff && !v2_ff && !v3_ff) begin
               state_in = found_ff ? ST_ROOT : ST_DONE;
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!outv_in) begin
               outv_in = 1'b1;
               if (found_ff) begin
                  out_in.found         = 1'b1;
                  out_in.near_x        = best_pt_ff[DW-1 -: COORD_W];
                  out_in.near_y        = best_pt_ff[DW-COORD_W-1 -: COORD_W];
                  out_in.near_z        = best_pt_ff[GROUP_W +: COORD_W];
                  out_in.near_group    = best_pt_ff[GROUP_W-1:0];
                  out_in.near_distance = root;
               end else begin
                  out_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         v0_ff    <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         found_ff <= 1'b0;
         outv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         v0_ff    <= v0_in;
         v1_ff    <= v0_ff;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         found_ff <= (state_ff == ST_IDLE) ? 1'b0 : found_in;
         outv_ff  <= outv_in;
      end
      idx_ff     <= idx_in;
      last_ff    <= last_in;
      q_ff       <= q_in;
      pt1_ff     <= ram_rdata;
      in1_ff     <= inside_in;
      pt2_ff     <= pt1_ff;
      in2_ff     <= in1_ff;
      pt3_ff     <= pt2_ff;
      in3_ff     <= in2_ff;
      for (int a = 0; a < 3; a++) begin
         d1_ff[a] <= d_in[a];
         s2_ff[a] <= d1_ff[a] * d1_ff[a];
      end
      sum3_ff    <= SQ_W'(s2_ff[0]) + SQ_W'(s2_ff[1]) + SQ_W'(s2_ff[2]);
      best_pt_ff <= best_pt_in;
      best_sq_ff <= best_sq_in;
      out_ff     <= out_in;
   end

   assign out_valid = outv_ff;
   assign result    = out_ff;
endmodule

[hdl/npob_checker.sv]
// Port-level checks of nearest_point_outside_box, bound to the top level.
// Depends on npob_pkg and nearest_point_outside_box_defines.svh.
`include "nearest_point_outside_box_defines.svh"
module npob_checker
   import npob_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_full,
   input logic                      rsp_empty,
   input logic                      rsp_pop,
   input logic                      rsp_found,
   input logic signed [COORD_W-1:0] rsp_near_x,
   input logic [GROUP_W-1:0]        rsp_near_group,
   input logic [ROOT_W-1:0]         rsp_near_distance,
   input logic                      csr_psel,
   input logic                      csr_penable,
   input logic                      csr_pwrite,
   input logic [2:0]                csr_paddr,
   input logic [31:0]               csr_pwdata,
   input logic [31:0]               csr_prdata
);
   `NPOB_ASSERT_ALWAYS(a_reset_empty, clock, reset, rsp_empty && !req_full)
   `NPOB_ASSERT_NOW(a_miss_zero, clock, reset, !rsp_empty && !rsp_found,
      rsp_near_distance == '0 && rsp_near_group == '0 && rsp_near_x == '0)
   `NPOB_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop,
      !rsp_empty && $stable(rsp_near_distance) && $stable(rsp_found))
   `NPOB_ASSERT_NEXT(a_csr_write, clock, reset,
      csr_psel && csr_penable && csr_pwrite && csr_paddr == 3'd0,
      csr_paddr != 3'd0 || csr_prdata[COUNT_W-1:0] == $past(csr_pwdata[COUNT_W-1:0]))
endmodule

bind nearest_point_outside_box npob_checker u_npob_checker (.*);
